[rtl/dwc_pkg.sv]
// shared widths, reset values and register indexes of the display window chunker
package dwc_pkg;

   localparam int COL_W       = 9;
   localparam int OUT_COL_W   = 10;
   localparam int ROW_W       = 9;
   localparam int ROWS_W      = 10;
   localparam int WIDTH_W     = 10;
   localparam int ROW_BYTES_W = 11;
   localparam int BYTES_W     = 17;
   localparam int OFFSET_W    = 20;
   localparam int COL_OFS_W   = 8;
   localparam int CSR_DATA_W  = 17;
   localparam int DIV_STEPS   = 17;
   localparam int DIV_CNT_W   = 5;
   localparam int PROD_W      = ROWS_W + ROW_BYTES_W;

   localparam logic [COL_OFS_W-1:0] COL_OFS_RESET   = 8'd20;
   localparam logic [BYTES_W-1:0]   MAX_BYTES_RESET = 17'd32768;

   typedef enum logic {
      CSR_COL_OFFSET = 1'b0,
      CSR_MAX_BYTES  = 1'b1
   } csr_idx_type;

endpackage

[rtl/display_window_chunker_top.sv]
// display window chunker: splits a screen window into row chunks for pixel transfers
//
// usage
//  - a window word (col_first, col_final, row_first, row_final) is taken at a
//    clock edge where start is high and busy is low
//  - after the divide, results come out one word per cycle on the rsp_
//    ports, marked by rsp_strobe for exactly one cycle; the receiver cannot
//    stall, every strobed word is taken
//  - an inverted window gives a single error word the cycle after start,
//    and the block is ready again right away
//  - otherwise the rows per chunk come from a bit-serial restoring divider
//    (max transfer bytes over row bytes), one quotient bit per cycle, then a
//    prep step forms the full chunk size
//  - first chunk word appears after the divide and prep steps, then one chunk
//    per cycle; a window gives at most MAX_CHUNKS chunk words
//  - busy stays high until the last chunk word, so no new window is taken before it
//  - csr_ port writes column offset (index 0) and max transfer bytes
//    (index 1) at any edge with csr_write_enable high; write only when idle
//  - synchronous reset returns to idle, drops the strobe and restores
//    column offset 20 and max transfer bytes 32768
module display_window_chunker_top
   import dwc_pkg::*;
#(
   parameter int MAX_CHUNKS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [COL_W-1:0]       req_col_first,
   input  logic [COL_W-1:0]       req_col_final,
   input  logic [ROW_W-1:0]       req_row_first,
   input  logic [ROW_W-1:0]       req_row_final,
   output logic                   rsp_strobe,
   output logic [OUT_COL_W-1:0]   rsp_chunk_col_start,
   output logic [OUT_COL_W-1:0]   rsp_chunk_col_end,
   output logic [ROW_W-1:0]       rsp_chunk_row_start,
   output logic [ROW_W-1:0]       rsp_chunk_row_end,
   output logic [OFFSET_W-1:0]    rsp_byte_offset,
   output logic [BYTES_W-1:0]     rsp_byte_count,
   output logic                   rsp_last_chunk,
   output logic                   rsp_window_error,
   input  logic                   csr_write_enable,
   input  logic                   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_CHUNKS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_PREP,
      ST_EMIT
   } state_type;

   // control and configuration
   state_type                state_ff, state_in;
   logic [DIV_CNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic [CNT_W-1:0]         chunk_cnt_ff, chunk_cnt_in;
   logic [COL_OFS_W-1:0]     col_ofs_ff, col_ofs_in;
   logic [BYTES_W-1:0]       max_bytes_ff, max_bytes_in;

   // per-window working registers
   logic [OUT_COL_W-1:0]     col_start_ff, col_start_in;
   logic [OUT_COL_W-1:0]     col_end_ff, col_end_in;
   logic [ROW_BYTES_W-1:0]   row_bytes_ff, row_bytes_in;
   logic [ROWS_W-1:0]        remain_ff, remain_in;
   logic [ROW_W-1:0]         row_pos_ff, row_pos_in;
   logic [ROW_W-1:0]         row_last_ff, row_last_in;
   logic [BYTES_W-1:0]       quo_ff, quo_in;
   logic [ROW_BYTES_W-1:0]   rem_ff, rem_in;
   logic [BYTES_W-1:0]       lines_ff, lines_in;
   logic [BYTES_W-1:0]       full_bytes_ff, full_bytes_in;
   logic [OFFSET_W-1:0]      offset_ff, offset_in;

   // result registers
   logic                     strobe_ff, strobe_in;
   logic [OUT_COL_W-1:0]     o_col_start_ff, o_col_start_in;
   logic [OUT_COL_W-1:0]     o_col_end_ff, o_col_end_in;
   logic [ROW_W-1:0]         o_row_start_ff, o_row_start_in;
   logic [ROW_W-1:0]         o_row_end_ff, o_row_end_in;
   logic [OFFSET_W-1:0]      o_offset_ff, o_offset_in;
   logic [BYTES_W-1:0]       o_count_ff, o_count_in;
   logic                     o_last_ff, o_last_in;
   logic                     o_err_ff, o_err_in;

   // datapath helpers
   logic                     accept;
   logic                     inverted;
   logic [WIDTH_W-1:0]       width;
   logic [ROW_BYTES_W:0]     trial;
   logic [ROW_BYTES_W:0]     trial_diff;
   logic                     trial_ge;
   logic                     rem_le;
   logic                     rem_lt;
   logic                     emit_last;
   logic [PROD_W-1:0]        tail_bytes;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign inverted = (req_col_final < req_col_first) || (req_row_final < req_row_first);
   assign width    = WIDTH_W'({1'b0, req_col_final} - {1'b0, req_col_first} + 10'd1);

   // one restoring divide step: shift in next dividend bit, try subtract
   assign trial      = {rem_ff, quo_ff[BYTES_W-1]};
   assign trial_diff = trial - {1'b0, row_bytes_ff};
   assign trial_ge   = (trial >= {1'b0, row_bytes_ff});

   assign rem_le     = ({7'b0, remain_ff} <= lines_ff);
   assign rem_lt     = ({7'b0, remain_ff} < lines_ff);
   assign emit_last  = rem_le || (chunk_cnt_ff == LAST_IDX);
   assign tail_bytes = PROD_W'(remain_ff) * PROD_W'(row_bytes_ff);

   always_comb begin
      state_in       = state_ff;
      div_cnt_in     = div_cnt_ff;
      chunk_cnt_in   = chunk_cnt_ff;
      col_ofs_in     = col_ofs_ff;
      max_bytes_in   = max_bytes_ff;
      col_start_in   = col_start_ff;
      col_end_in     = col_end_ff;
      row_bytes_in   = row_bytes_ff;
      remain_in      = remain_ff;
      row_pos_in     = row_pos_ff;
      row_last_in    = row_last_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      lines_in       = lines_ff;
      full_bytes_in  = full_bytes_ff;
      offset_in      = offset_ff;
      strobe_in      = 1'b0;
      o_col_start_in = o_col_start_ff;
      o_col_end_in   = o_col_end_ff;
      o_row_start_in = o_row_start_ff;
      o_row_end_in   = o_row_end_ff;
      o_offset_in    = o_offset_ff;
      o_count_in     = o_count_ff;
      o_last_in      = o_last_ff;
      o_err_in       = o_err_ff;

      if (csr_write_enable) begin
         case (csr_idx_type'(csr_index))
            CSR_COL_OFFSET: col_ofs_in   = csr_write_data[COL_OFS_W-1:0];
            CSR_MAX_BYTES:  max_bytes_in = csr_write_data[BYTES_W-1:0];
            default:        ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (inverted) begin
                  // single error word, data fields cleared, last and error flags set
                  strobe_in      = 1'b1;
                  o_col_start_in = '0;
                  o_col_end_in   = '0;
                  o_row_start_in = '0;
                  o_row_end_in   = '0;
                  o_offset_in    = '0;
                  o_count_in     = '0;
                  o_last_in      = 1'b1;
                  o_err_in       = 1'b1;
               end else begin
                  col_start_in = {1'b0, req_col_first} + {2'b0, col_ofs_ff};
                  col_end_in   = {1'b0, req_col_final} + {2'b0, col_ofs_ff};
                  row_bytes_in = {width, 1'b0};
                  remain_in    = ROWS_W'({1'b0, req_row_final} - {1'b0, req_row_first} + 10'd1);
                  row_pos_in   = req_row_first;
                  row_last_in  = req_row_final;
                  quo_in       = max_bytes_ff;
                  rem_in       = '0;
                  div_cnt_in   = '0;
                  chunk_cnt_in = '0;
                  offset_in    = '0;
                  state_in     = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in     = trial_ge ? trial_diff[ROW_BYTES_W-1:0] : trial[ROW_BYTES_W-1:0];
            quo_in     = {quo_ff[BYTES_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // a transfer smaller than one row still moves one row per chunk
            if (quo_ff == '0) begin
               lines_in      = 17'd1;
               full_bytes_in = {6'b0, row_bytes_ff};
            end else begin
               lines_in      = quo_ff;
               full_bytes_in = max_bytes_ff - {6'b0, rem_ff};
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            strobe_in      = 1'b1;
            o_col_start_in = col_start_ff;
            o_col_end_in   = col_end_ff;
            o_row_start_in = row_pos_ff;
            o_row_end_in   = rem_le ? row_last_ff
                                    : ROW_W'(row_pos_ff + lines_ff[ROW_W-1:0] - 9'd1);
            o_offset_in    = offset_ff;
            o_count_in     = rem_lt ? tail_bytes[BYTES_W-1:0] : full_bytes_ff;
            o_last_in      = emit_last;
            o_err_in       = 1'b0;
            row_pos_in     = ROW_W'(row_pos_ff + lines_ff[ROW_W-1:0]);
            offset_in      = OFFSET_W'(offset_ff + {3'b0, full_bytes_ff});
            chunk_cnt_in   = chunk_cnt_ff + CNT_W'(1);
            if (!rem_le) begin
               remain_in = remain_ff - lines_ff[ROWS_W-1:0];
            end
            if (emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         chunk_cnt_ff <= '0;
         col_ofs_ff   <= COL_OFS_RESET;
         max_bytes_ff <= MAX_BYTES_RESET;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         chunk_cnt_ff <= chunk_cnt_in;
         col_ofs_ff   <= col_ofs_in;
         max_bytes_ff <= max_bytes_in;
         strobe_ff    <= strobe_in;
      end
      col_start_ff   <= col_start_in;
      col_end_ff     <= col_end_in;
      row_bytes_ff   <= row_bytes_in;
      remain_ff      <= remain_in;
      row_pos_ff     <= row_pos_in;
      row_last_ff    <= row_last_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      lines_ff       <= lines_in;
      full_bytes_ff  <= full_bytes_in;
      offset_ff      <= offset_in;
      o_col_start_ff <= o_col_start_in;
      o_col_end_ff   <= o_col_end_in;
      o_row_start_ff <= o_row_start_in;
      o_row_end_ff   <= o_row_end_in;
      o_offset_ff    <= o_offset_in;
      o_count_ff     <= o_count_in;
      o_last_ff      <= o_last_in;
      o_err_ff       <= o_err_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_chunk_col_start = o_col_start_ff;
   assign rsp_chunk_col_end   = o_col_end_ff;
   assign rsp_chunk_row_start = o_row_start_ff;
   assign rsp_chunk_row_end   = o_row_end_ff;
   assign rsp_byte_offset     = o_offset_ff;
   assign rsp_byte_count      = o_count_ff;
   assign rsp_last_chunk      = o_last_ff;
   assign rsp_window_error    = o_err_ff;

   // error word always closes the window
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_window_error) |-> rsp_last_chunk)
      else $error("error word without last flag");

   // no result word leaves while the divider runs
   a_quiet_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |=> !rsp_strobe)
      else $error("result strobe during divide");

   // a valid window always starts the divider
   a_valid_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && !inverted) |=> (state_ff == ST_DIV))
      else $error("valid window did not start divide");

   // chunking never runs with zero rows per chunk
   a_lines_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (lines_ff != '0))
      else $error("zero rows per chunk");

   // busy drops only right after the last word of a window
   a_busy_ends_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe && rsp_last_chunk))
      else $error("busy dropped without last chunk");

endmodule
